// ===== src/priority_task_timer_scheduler_core_assert.svh =====
// Assertion macros for the priority task timer scheduler
`ifndef PRIORITY_TASK_TIMER_SCHEDULER_CORE_ASSERT_SVH
`define PRIORITY_TASK_TIMER_SCHEDULER_CORE_ASSERT_SVH
// same-cycle implication
`define PTTS_ASSERT_IMPL(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication
`define PTTS_ASSERT_NEXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

// ===== src/ptts_pkg.sv =====
// Package: types, codes and helpers for the priority task timer scheduler
`timescale 1ns / 1ps
package ptts_pkg;
  localparam int TASK_COUNT_DEF = 8;
  localparam int MAX_TASKS = 16;

  typedef enum logic [2:0] {
    OP_REGISTER   = 3'd0,
    OP_UNREGISTER = 3'd1,
    OP_TICK       = 3'd2,
    OP_DISPATCH   = 3'd3,
    OP_DONE       = 3'd4
  } op_t;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BOUNDS  = 3'd1;
  localparam logic [2:0] ST_BUSY    = 3'd2;
  localparam logic [2:0] ST_NOREADY = 3'd3;
  localparam logic [2:0] ST_NORUN   = 3'd4;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_WALK,
    S_EMIT,
    S_WAIT
  } state_t;

  typedef struct packed {
    logic        walk;
    logic [2:0]  op;
    logic [3:0]  idx;
    logic [4:0]  lvlp1;
    logic        wr_reg;
    logic        wr_unreg;
    logic [3:0]  prio;
    logic [15:0] phasing;
    logic [15:0] period;
    logic        treq;
    logic        dir;
  } tbl_cmd_t;

  typedef struct packed {
    logic fire_dir;
    logic fire_pend;
    logic pick;
    logic work;
    logic proc;
    logic used_at_prio;
  } tbl_stat_t;

  // highest set bit of a mask; valid low when the mask is empty
  function automatic logic [4:0] hi_bit(input logic [MAX_TASKS-1:0] m);
    logic [4:0] r;
    r = 5'd0;
    for (int i = 0; i < MAX_TASKS; i++) begin
      if (m[i]) r = {1'b1, 4'(i)};
    end
    return r;
  endfunction
endpackage

// ===== src/ptts_table.sv =====
// Task slot table with the shared per-slot update unit
`timescale 1ns / 1ps
module ptts_table import ptts_pkg::*; #(
  parameter int TASK_COUNT = TASK_COUNT_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  tbl_cmd_t  cmd,
  output tbl_stat_t stat
);
  localparam int IW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

  logic [TASK_COUNT-1:0] used_r, periodic_r, timed_r, direct_r;
  logic [15:0] ticks_r  [TASK_COUNT];
  logic [15:0] reload_r [TASK_COUNT];
  logic [7:0]  fired_r  [TASK_COUNT];
  logic [7:0]  served_r [TASK_COUNT];

  logic [IW-1:0] wi, pi;
  logic          u, t, differ;
  logic [15:0]   tl;

  assign wi = cmd.idx[IW-1:0];
  assign pi = cmd.prio[IW-1:0];
  assign u  = used_r[wi];
  assign t  = timed_r[wi];
  assign tl = ticks_r[wi];
  assign differ = fired_r[wi] != served_r[wi];

  always_comb begin
    stat = '0;
    stat.used_at_prio = used_r[pi];
    stat.proc = {1'b0, cmd.idx} >= cmd.lvlp1;
    if (cmd.walk) begin
      case (cmd.op)
        OP_TICK: begin
          if (u && t && tl == 16'd0) begin
            stat.fire_dir  = direct_r[wi];
            stat.fire_pend = !direct_r[wi] && stat.proc;
          end
        end
        OP_DISPATCH: stat.pick = stat.proc && differ && u;
        OP_DONE:     stat.work = stat.proc && differ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r     <= '0;
      periodic_r <= '0;
      timed_r    <= '0;
      direct_r   <= '0;
      for (int i = 0; i < TASK_COUNT; i++) begin
        fired_r[i]  <= 8'd0;
        served_r[i] <= 8'd0;
      end
    end else begin
      if (cmd.wr_reg) begin
        ticks_r[pi]    <= cmd.phasing;
        reload_r[pi]   <= cmd.period;
        fired_r[pi]    <= 8'd0;
        served_r[pi]   <= 8'd0;
        periodic_r[pi] <= cmd.period != 16'd0;
        timed_r[pi]    <= cmd.phasing != 16'd0 || cmd.period != 16'd0 || cmd.treq;
        direct_r[pi]   <= cmd.dir;
        used_r[pi]     <= 1'b1;
      end
      if (cmd.wr_unreg) begin
        used_r[pi]     <= 1'b0;
        periodic_r[pi] <= 1'b0;
        timed_r[pi]    <= 1'b0;
        direct_r[pi]   <= 1'b0;
      end
      if (cmd.walk) begin
        case (cmd.op)
          OP_TICK: begin
            if (u && t) begin
              if (tl != 16'd0) begin
                ticks_r[wi] <= tl - 16'd1;
              end else begin
                fired_r[wi] <= fired_r[wi] + 8'd1;
                if (periodic_r[wi]) ticks_r[wi] <= reload_r[wi] - 16'd1;
                else timed_r[wi] <= 1'b0;
                if (direct_r[wi]) served_r[wi] <= served_r[wi] + 8'd1;
              end
            end
          end
          OP_DISPATCH: begin
            if (stat.proc && differ) begin
              if (!u) served_r[wi] <= fired_r[wi];
              else served_r[wi] <= served_r[wi] + 8'd1;
            end
          end
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== src/priority_task_timer_scheduler_core.sv =====
// Top level: sequencer, running mask and result register of the scheduler
// One beat in, one to TASK_COUNT+1 beats out. Register, unregister, unknown ops
// and done with nothing running go from the exec state straight to the emit
// state, which registers their result beat. Tick, dispatch and done walk the
// slot table one slot per cycle through the shared update unit before the emit
// state, and a tick emits a beat for each direct run reported ahead of its
// final beat. An output stall holds each beat until it is taken. The input
// stalls from acceptance until the final beat is taken.
`timescale 1ns / 1ps
`include "priority_task_timer_scheduler_core_assert.svh"
module priority_task_timer_scheduler_core import ptts_pkg::*; #(
  parameter int TASK_COUNT = TASK_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_op,
  input  logic [3:0]  in_prio,
  input  logic [15:0] in_phasing,
  input  logic [15:0] in_period,
  input  logic        in_timed_request,
  input  logic        in_direct,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic        out_run_valid,
  output logic [3:0]  out_task_res,
  output logic        out_is_direct,
  output logic        out_pending_out,
  output logic        out_last
);
  localparam int IW = (TASK_COUNT > 1) ? $clog2(TASK_COUNT) : 1;

  state_t state_r, state_nxt;
  logic [2:0]  op_r;
  logic [3:0]  prio_r;
  logic [15:0] phasing_r, period_r;
  logic        treq_r, dir_r;
  logic [3:0]  idx_r;
  logic [4:0]  lvlp1_r;
  logic        pend_r, pending_r;
  logic [TASK_COUNT-1:0] dmask_r, run_mask_r;
  logic [2:0]  status_r;
  logic        run_r;
  logic [3:0]  task_r;

  logic        ov_r, olast_r, odir_r, orun_r;
  logic [2:0]  ostat_r;
  logic [3:0]  otask_r;

  tbl_cmd_t  cmd;
  tbl_stat_t stat;
  logic [4:0] lvl_hb, new_hb, dm_hb;
  logic [TASK_COUNT-1:0] cleared;
  logic prio_oob, walk_end;

  assign lvl_hb  = hi_bit(MAX_TASKS'(run_mask_r));
  assign cleared = run_mask_r & ~(TASK_COUNT'(1) << lvl_hb[3:0]);
  assign new_hb  = hi_bit(MAX_TASKS'(cleared));
  assign dm_hb   = hi_bit(MAX_TASKS'(dmask_r));
  assign prio_oob = {1'b0, prio_r} >= 5'(TASK_COUNT);
  assign walk_end = idx_r == 4'd0 || stat.pick || (op_r != OP_TICK && !stat.proc);

  ptts_table #(.TASK_COUNT(TASK_COUNT)) u_table (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .stat(stat)
  );

  always_comb begin
    cmd = '0;
    cmd.op      = op_r;
    cmd.idx     = idx_r;
    cmd.lvlp1   = lvlp1_r;
    cmd.prio    = prio_r;
    cmd.phasing = phasing_r;
    cmd.period  = period_r;
    cmd.treq    = treq_r;
    cmd.dir     = dir_r;
    cmd.walk    = state_r == S_WALK;
    cmd.wr_reg  = state_r == S_EXEC && op_r == OP_REGISTER && !prio_oob &&
                  !stat.used_at_prio;
    cmd.wr_unreg = state_r == S_EXEC && op_r == OP_UNREGISTER && !prio_oob;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: if (in_valid) state_nxt = S_EXEC;
      S_EXEC: begin
        if (op_r == OP_TICK || op_r == OP_DISPATCH ||
            (op_r == OP_DONE && lvl_hb[4])) state_nxt = S_WALK;
        else state_nxt = S_EMIT;
      end
      S_WALK: if (walk_end) state_nxt = S_EMIT;
      S_EMIT: state_nxt = S_WAIT;
      S_WAIT: if (!out_stall) state_nxt = olast_r ? S_IDLE : S_EMIT;
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_stall = state_r != S_IDLE;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      pending_r  <= 1'b0;
      run_mask_r <= '0;
      dmask_r    <= '0;
      ov_r       <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            op_r      <= in_op;
            prio_r    <= in_prio;
            phasing_r <= in_phasing;
            period_r  <= in_period;
            treq_r    <= in_timed_request;
            dir_r     <= in_direct;
          end
        end
        S_EXEC: begin
          idx_r    <= 4'(TASK_COUNT - 1);
          dmask_r  <= '0;
          run_r    <= 1'b0;
          task_r   <= 4'd0;
          pend_r   <= op_r == OP_TICK ? pending_r : 1'b0;
          if (op_r == OP_DONE && lvl_hb[4]) begin
            run_mask_r <= cleared;
            lvlp1_r <= new_hb[4] ? 5'(new_hb[3:0]) + 5'd1 : 5'd0;
          end else begin
            lvlp1_r <= lvl_hb[4] ? 5'(lvl_hb[3:0]) + 5'd1 : 5'd0;
          end
          case (op_r)
            OP_REGISTER: begin
              if (prio_oob) status_r <= ST_BOUNDS;
              else if (stat.used_at_prio) status_r <= ST_BUSY;
              else status_r <= ST_OK;
            end
            OP_UNREGISTER: status_r <= prio_oob ? ST_BOUNDS : ST_OK;
            OP_DISPATCH: status_r <= ST_NOREADY;
            OP_DONE: status_r <= lvl_hb[4] ? ST_OK : ST_NORUN;
            default: status_r <= ST_OK;
          endcase
        end
        S_WALK: begin
          idx_r <= idx_r - 4'd1;
          if (stat.fire_dir) dmask_r[idx_r[IW-1:0]] <= 1'b1;
          if (stat.fire_pend || stat.work) pend_r <= 1'b1;
          if (stat.pick) begin
            run_mask_r[idx_r[IW-1:0]] <= 1'b1;
            status_r <= ST_OK;
            run_r    <= 1'b1;
            task_r   <= idx_r;
          end
          if (walk_end) pending_r <= stat.fire_pend || stat.work || pend_r;
        end
        S_EMIT: begin
          ov_r <= 1'b1;
          if (dm_hb[4]) begin
            dmask_r[dm_hb[IW-1:0]] <= 1'b0;
            ostat_r <= ST_OK;
            orun_r  <= 1'b1;
            otask_r <= dm_hb[3:0];
            odir_r  <= 1'b1;
            olast_r <= 1'b0;
          end else begin
            ostat_r <= status_r;
            orun_r  <= run_r;
            otask_r <= task_r;
            odir_r  <= 1'b0;
            olast_r <= 1'b1;
          end
        end
        S_WAIT: if (!out_stall) ov_r <= 1'b0;
        default: ;
      endcase
    end
  end

  assign out_valid       = ov_r;
  assign out_status      = ostat_r;
  assign out_run_valid   = orun_r;
  assign out_task_res    = otask_r;
  assign out_is_direct   = odir_r;
  assign out_pending_out = pending_r;
  assign out_last        = olast_r;

  `PTTS_ASSERT_IMPL(a_out_busy, clk, rst_n, out_valid, in_stall)
  `PTTS_ASSERT_IMPL(a_dir_notlast, clk, rst_n, out_valid && out_is_direct, !out_last)
  `PTTS_ASSERT_IMPL(a_dmask_idle, clk, rst_n, state_r == S_IDLE, dmask_r == '0)
  `PTTS_ASSERT_NEXT(a_last_idle, clk, rst_n, out_valid && !out_stall && out_last,
                    !in_stall)
endmodule

// ===== dv/testbench.sv =====
// Testbench for the priority task timer scheduler core: directed and random op streams
`timescale 1ns / 1ps
module testbench;
  import ptts_pkg::*;

  localparam int NT = 8;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct packed {
    logic [2:0] status;
    logic       run_valid;
    logic [3:0] task_res;
    logic       is_direct;
    logic       pending_out;
    logic       last;
  } sched_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_op = '0;
  logic [3:0] in_prio = '0;
  logic [15:0] in_phasing = '0;
  logic [15:0] in_period = '0;
  logic in_timed_request = 1'b0;
  logic in_direct = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [2:0] out_status;
  logic out_run_valid;
  logic [3:0] out_task_res;
  logic out_is_direct;
  logic out_pending_out;
  logic out_last;

  priority_task_timer_scheduler_core #(.TASK_COUNT(NT)) uut (.*);

  always #2 clk = ~clk;

  // scheduler shadow state
  logic        sh_used [NT];
  logic        sh_periodic [NT];
  logic        sh_timed [NT];
  logic        sh_direct [NT];
  logic [15:0] sh_ticks [NT];
  logic [15:0] sh_reload [NT];
  logic [7:0]  sh_fired [NT];
  logic [7:0]  sh_served [NT];
  logic [NT-1:0] sh_running;
  logic        sh_pending;

  sched_res_t expected_beats[$];
  int errors = 0;
  int items_sent = 0;
  int beats_seen = 0;
  int directs_seen = 0;
  int dispatches_seen = 0;
  int idle_cycles = 0;
  bit idling_on = 1'b1;

  function automatic int running_level();
    int lvl;
    lvl = -1;
    for (int i = 0; i < NT; i++) if (sh_running[i]) lvl = i;
    return lvl;
  endfunction

  function automatic logic unserved_above(int lvl);
    for (int i = NT - 1; i > lvl; i--) if (sh_fired[i] != sh_served[i]) return 1'b1;
    return 1'b0;
  endfunction

  function automatic sched_res_t mk(logic [2:0] st, logic rv, logic [3:0] t, logic d, logic l);
    sched_res_t r;
    r = '{st, rv, t, d, 1'b0, l};
    return r;
  endfunction

  task automatic predict_schedule(input logic [2:0] op, input logic [3:0] prio,
      input logic [15:0] ph, input logic [15:0] per, input logic treq, input logic dir);
    sched_res_t beats[$];
    int lvl;
    int pick;
    case (op)
      OP_REGISTER: begin
        if (prio >= NT) beats.push_back(mk(ST_BOUNDS, 0, 0, 0, 1));
        else if (sh_used[prio]) beats.push_back(mk(ST_BUSY, 0, 0, 0, 1));
        else begin
          sh_ticks[prio] = ph;
          sh_reload[prio] = per;
          sh_fired[prio] = 0;
          sh_served[prio] = 0;
          sh_periodic[prio] = per != 0;
          sh_timed[prio] = ph != 0 || per != 0 || treq;
          sh_direct[prio] = dir;
          sh_used[prio] = 1'b1;
          beats.push_back(mk(ST_OK, 0, 0, 0, 1));
        end
      end
      OP_UNREGISTER: begin
        if (prio >= NT) beats.push_back(mk(ST_BOUNDS, 0, 0, 0, 1));
        else begin
          sh_used[prio] = 0;
          sh_periodic[prio] = 0;
          sh_timed[prio] = 0;
          sh_direct[prio] = 0;
          beats.push_back(mk(ST_OK, 0, 0, 0, 1));
        end
      end
      OP_TICK: begin
        lvl = running_level();
        for (int i = NT - 1; i >= 0; i--) begin
          if (!sh_used[i] || !sh_timed[i]) continue;
          if (sh_ticks[i] != 0) begin
            sh_ticks[i] = sh_ticks[i] - 16'd1;
            continue;
          end
          sh_fired[i] = sh_fired[i] + 8'd1;
          if (sh_periodic[i]) sh_ticks[i] = sh_reload[i] - 16'd1;
          else sh_timed[i] = 0;
          if (sh_direct[i]) begin
            sh_served[i] = sh_served[i] + 8'd1;
            beats.push_back(mk(ST_OK, 1, 4'(i), 1, 0));
          end else if (i > lvl) sh_pending = 1'b1;
        end
        beats.push_back(mk(ST_OK, 0, 0, 0, 1));
      end
      OP_DISPATCH: begin
        lvl = running_level();
        pick = -1;
        for (int i = NT - 1; i > lvl; i--) begin
          if (sh_fired[i] == sh_served[i]) continue;
          if (!sh_used[i]) begin
            sh_served[i] = sh_fired[i];
            continue;
          end
          pick = i;
          break;
        end
        if (pick < 0) begin
          sh_pending = unserved_above(lvl);
          beats.push_back(mk(ST_NOREADY, 0, 0, 0, 1));
        end else begin
          sh_served[pick] = sh_served[pick] + 8'd1;
          sh_running[pick] = 1'b1;
          sh_pending = unserved_above(pick);
          beats.push_back(mk(ST_OK, 1, 4'(pick), 0, 1));
        end
      end
      OP_DONE: begin
        lvl = running_level();
        if (lvl < 0) beats.push_back(mk(ST_NORUN, 0, 0, 0, 1));
        else begin
          sh_running[lvl] = 1'b0;
          sh_pending = unserved_above(running_level());
          beats.push_back(mk(ST_OK, 0, 0, 0, 1));
        end
      end
      default: beats.push_back(mk(ST_OK, 0, 0, 0, 1));
    endcase
    foreach (beats[k]) begin
      beats[k].pending_out = sh_pending;
      expected_beats.push_back(beats[k]);
    end
  endtask

  task automatic send_op(input logic [2:0] op, input logic [3:0] prio,
      input logic [15:0] ph = 0, input logic [15:0] per = 0,
      input logic treq = 0, input logic dir = 0);
    int gap;
    @(negedge clk);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_prio <= prio;
    in_phasing <= ph;
    in_period <= per;
    in_timed_request <= treq;
    in_direct <= dir;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_schedule(op, prio, ph, per, treq, dir);
    items_sent++;
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  // output stall bursts
  initial begin
    int burst;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (idling_on && $urandom_range(0, 7) == 0) begin
        burst = $urandom_range(1, 19);
        out_stall <= 1'b1;
        repeat (burst) @(negedge clk);
      end
      out_stall <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    sched_res_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_status, out_run_valid, out_task_res, out_is_direct, out_pending_out, out_last};
      beats_seen++;
      if (out_is_direct) directs_seen++;
      if (out_run_valid && !out_is_direct) dispatches_seen++;
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat, actual %p", $time, got);
        errors++;
      end else begin
        want = expected_beats.pop_front();
        if (got !== want) begin
          $display("%0t: mismatch, expected %p actual %p", $time, want, got);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic test_register_bounds_busy();
    send_op(OP_REGISTER, 4'd15, 16'hFFFF, 16'hFFFF, 1, 1);
    send_op(OP_REGISTER, 4'd8, 0, 0, 0, 0);
    send_op(OP_UNREGISTER, 4'd12);
    send_op(OP_REGISTER, 4'd7, 16'd0, 16'd0, 1, 0);
    send_op(OP_REGISTER, 4'd7, 16'd3, 16'd3, 0, 0);
    send_op(OP_REGISTER, 4'd0, 16'd0, 16'd0, 0, 0);
    send_op(3'd5, 4'd0);
    send_op(3'd7, 4'd3);
  endtask

  task automatic test_tick_direct_dispatch();
    send_op(OP_DONE, 4'd0);
    send_op(OP_DISPATCH, 4'd0);
    send_op(OP_REGISTER, 4'd5, 16'd1, 16'd2, 0, 1);
    send_op(OP_REGISTER, 4'd3, 16'd0, 16'd1, 0, 0);
    send_op(OP_TICK, 4'd0);
    send_op(OP_TICK, 4'd0);
    send_op(OP_DISPATCH, 4'd0);
    send_op(OP_DISPATCH, 4'd0);
    send_op(OP_TICK, 4'd0);
    send_op(OP_DONE, 4'd0);
    send_op(OP_UNREGISTER, 4'd7);
    send_op(OP_DISPATCH, 4'd0);
    send_op(OP_DONE, 4'd0);
    send_op(OP_DONE, 4'd0);
    send_op(OP_REGISTER, 4'd7, 16'd0, 16'd0, 0, 1);
  endtask

  task automatic test_random_traffic(input int count);
    logic [2:0] op;
    int r;
    for (int n = 0; n < count; n++) begin
      r = $urandom_range(0, 99);
      if (r < 20) op = OP_REGISTER;
      else if (r < 28) op = OP_UNREGISTER;
      else if (r < 63) op = OP_TICK;
      else if (r < 80) op = OP_DISPATCH;
      else if (r < 95) op = OP_DONE;
      else op = 3'($urandom_range(5, 7));
      if ($urandom_range(0, 9) == 0)
        send_op(op, 4'($urandom), 16'($urandom), 16'($urandom), 1'($urandom), 1'($urandom));
      else
        send_op(op, 4'($urandom_range(0, NT - 1 + ($urandom_range(0, 5) == 0))),
                16'($urandom_range(0, 4)), 16'($urandom_range(0, 4)),
                1'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    int wait_cycles;
    for (int i = 0; i < NT; i++) begin
      sh_used[i] = 0; sh_periodic[i] = 0; sh_timed[i] = 0; sh_direct[i] = 0;
      sh_ticks[i] = 0; sh_reload[i] = 0; sh_fired[i] = 0; sh_served[i] = 0;
    end
    sh_running = '0;
    sh_pending = 0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_register_bounds_busy();
    test_tick_direct_dispatch();
    test_random_traffic(230);
    idling_on = 1'b0;
    test_random_traffic(70);
    wait_cycles = 0;
    while (expected_beats.size() != 0 && wait_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (2 * NT + 8) @(posedge clk);
    if (expected_beats.size() != 0) begin
      $display("%0t: %0d expected beats never arrived", $time, expected_beats.size());
      errors++;
    end
    $display("Sent %0d ops, checked %0d result beats", items_sent, beats_seen);
    $display("Saw %0d direct runs and %0d dispatched tasks", directs_seen, dispatches_seen);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
